// ----- rtl/knnsc_pkg.sv -----
// ----------------------------------------------------------------------------
// knnsc_pkg: shared types and constants
// Sizes, codes and sequencer states for the symmetric kNN row builder.
// ----------------------------------------------------------------------------
package knnsc_pkg;

  localparam int MaxVertices  = 256;
  localparam int MaxNeighbors = 16;
  localparam int LoadDepth    = MaxVertices * MaxNeighbors;
  localparam int RowDepth     = 2 * LoadDepth;

  localparam int VidW  = $clog2(MaxVertices);        // vertex id
  localparam int VcntW = $clog2(MaxVertices + 1);    // vertex count
  localparam int NcntW = $clog2(MaxNeighbors + 1);   // neighbors per row
  localparam int LaW   = $clog2(LoadDepth);          // load store address
  localparam int LcntW = $clog2(LoadDepth + 1);      // loaded count
  localparam int RaW   = $clog2(RowDepth);           // row store address
  localparam int PosW  = $clog2(RowDepth + 1);       // row position / offset
  localparam int DistW = 32;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_BUILD = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_RANK      = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_BUILT = 3'd4;

  localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [1:0] REG_NEIGHBORS    = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DONE,
    S_Q1, S_Q2, S_Q3,
    S_VSTART, S_SRD, S_SCHK, S_SUPD,
    S_UCHK, S_UKEY, S_SHRD, S_SHCMP, S_VEND
  } state_t;

  // Row order: distance first, then neighbor id.
  function automatic logic key_after(input logic [DistW-1:0] da, input logic [VidW-1:0] na,
                                     input logic [DistW-1:0] db, input logic [VidW-1:0] nb);
    key_after = (da != db) ? (da > db) : (na > nb);
  endfunction

endpackage

// ----- rtl/knn_graph_symmetric_csr_builder_core.sv -----
// ----------------------------------------------------------------------------
// knn_graph_symmetric_csr_builder_core: symmetric kNN graph to compressed rows
// Collects directed edges, builds sorted symmetric rows, answers row queries.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a clock edge with start high and busy low; in_func
//   picks load edge, build rows or query row entry. Every request gives one
//   result, shown for one cycle with out_valid high. The receiver cannot
//   stall, so results are never held.
//   A load or no-op request passes the states S_EXEC and S_DONE before the
//   strobe; a query also passes S_Q1, S_Q2 and S_Q3 (two reads of the offset
//   memory, one of the row memory). busy is high from the cycle after accept
//   until the strobe. A build runs a sequencer over every vertex: for each
//   vertex it scans the whole load store (one read of the load memory per
//   edge and a read-modify-write of the per-neighbor best distance), then
//   inserts each unique neighbor into its row by insertion sort, shifting
//   one entry at a time through the single port pair of the row memory.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once,
//   empty the load store and drop the built graph; write only while idle.
//   Reset (rst_n low, synchronous) restores register defaults, empties the
//   load store and marks the graph unbuilt. No memory clearing is needed.
// ----------------------------------------------------------------------------
module knn_graph_symmetric_csr_builder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_source_vertex,
  input  logic [7:0]  in_target_vertex,
  input  logic [31:0] in_edge_distance,
  input  logic [7:0]  in_query_vertex,
  input  logic [7:0]  in_query_rank,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_neighbor_id,
  output logic [31:0] out_neighbor_distance,
  output logic [7:0]  out_row_degree,
  output logic [13:0] out_total_edges,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_wdata
);

  localparam int VidW  = knnsc_pkg::VidW;
  localparam int VcntW = knnsc_pkg::VcntW;
  localparam int NcntW = knnsc_pkg::NcntW;
  localparam int LaW   = knnsc_pkg::LaW;
  localparam int LcntW = knnsc_pkg::LcntW;
  localparam int RaW   = knnsc_pkg::RaW;
  localparam int PosW  = knnsc_pkg::PosW;
  localparam int DistW = knnsc_pkg::DistW;
  localparam int LdW   = 2 * VidW + DistW;
  localparam int RwW   = VidW + DistW;

  knnsc_pkg::state_t state_r, state_nxt;

  // configuration and global state
  logic [VcntW-1:0] vc_r, vc_nxt;
  logic [NcntW-1:0] npr_r, npr_nxt;
  logic [LcntW-1:0] loaded_r, loaded_nxt;
  logic             built_r, built_nxt;
  logic [PosW-1:0]  total_r, total_nxt;

  // latched request
  logic [1:0]       func_r, func_nxt;
  logic [VidW-1:0]  src_r, src_nxt, dst_r, dst_nxt, qv_r, qv_nxt, qr_r, qr_nxt;
  logic [DistW-1:0] dist_r, dist_nxt;

  // build sequencer
  logic [VcntW-1:0] v_r, v_nxt, u_r, u_nxt;
  logic [LcntW-1:0] e_r, e_nxt;
  logic [PosW-1:0]  pos_r, pos_nxt, start_r, start_nxt, j_r, j_nxt, base_r, base_nxt;
  logic [DistW-1:0] key_d_r, key_d_nxt;
  logic [VidW-1:0]  key_n_r, key_n_nxt;
  logic [knnsc_pkg::MaxVertices-1:0] seen_r, seen_nxt;

  // result holding
  logic [2:0]       stat_r, stat_nxt;
  logic [VidW-1:0]  nid_r, nid_nxt, deg_r, deg_nxt;
  logic [DistW-1:0] ndist_r, ndist_nxt;
  logic             ov_r, ov_nxt;
  logic [2:0]       os_r, os_nxt;
  logic [VidW-1:0]  on_r, on_nxt, odeg_r, odeg_nxt;
  logic [DistW-1:0] od_r, od_nxt;
  logic [13:0]      ot_r, ot_nxt;

  // memories
  logic [LdW-1:0]   lmem [knnsc_pkg::LoadDepth];
  logic             l_we;
  logic [LaW-1:0]   l_raddr;
  logic [LdW-1:0]   lrd_r;

  logic [DistW-1:0] bmem [knnsc_pkg::MaxVertices];
  logic             b_we;
  logic [VidW-1:0]  b_waddr, b_raddr;
  logic [DistW-1:0] b_wdata, brd_r;

  logic [PosW-1:0]  omem [knnsc_pkg::MaxVertices + 1];
  logic             o_we;
  logic [VcntW-1:0] o_waddr, o_raddr;
  logic [PosW-1:0]  o_wdata, ord_r;

  logic [RwW-1:0]   rmem [knnsc_pkg::RowDepth];
  logic             r_we;
  logic [RaW-1:0]   r_waddr, r_raddr;
  logic [RwW-1:0]   r_wdata, rrd_r;

  // combinational helpers
  logic [PosW-1:0]  cap;
  logic [VidW-1:0]  ls, lt, nbr;
  logic [DistW-1:0] ld;
  logic [PosW-1:0]  deg_w;
  logic [VcntW-1:0] v_inc;

  assign cap   = PosW'(vc_r) * PosW'(npr_r);
  assign ls    = lrd_r[LdW-1 -: VidW];
  assign lt    = lrd_r[DistW +: VidW];
  assign ld    = lrd_r[DistW-1:0];
  assign nbr   = (ls == v_r[VidW-1:0]) ? lt : ls;
  assign deg_w = ord_r - base_r;
  assign v_inc = v_r + VcntW'(1);

  assign busy                  = (state_r != knnsc_pkg::S_IDLE);
  assign out_valid             = ov_r;
  assign out_status            = os_r;
  assign out_neighbor_id       = on_r;
  assign out_neighbor_distance = od_r;
  assign out_row_degree        = odeg_r;
  assign out_total_edges       = ot_r;

  always_comb begin
    state_nxt = state_r;
    vc_nxt = vc_r; npr_nxt = npr_r; loaded_nxt = loaded_r;
    built_nxt = built_r; total_nxt = total_r;
    func_nxt = func_r; src_nxt = src_r; dst_nxt = dst_r; dist_nxt = dist_r;
    qv_nxt = qv_r; qr_nxt = qr_r;
    v_nxt = v_r; u_nxt = u_r; e_nxt = e_r; pos_nxt = pos_r; start_nxt = start_r;
    j_nxt = j_r; base_nxt = base_r; key_d_nxt = key_d_r; key_n_nxt = key_n_r;
    seen_nxt = seen_r;
    stat_nxt = stat_r; nid_nxt = nid_r; deg_nxt = deg_r; ndist_nxt = ndist_r;
    ov_nxt = 1'b0; os_nxt = os_r; on_nxt = on_r; odeg_nxt = odeg_r;
    od_nxt = od_r; ot_nxt = ot_r;
    l_we = 1'b0; l_raddr = e_r[LaW-1:0];
    b_we = 1'b0; b_waddr = key_n_r; b_wdata = key_d_r; b_raddr = nbr;
    o_we = 1'b0; o_waddr = v_inc; o_wdata = pos_r; o_raddr = {1'b0, qv_r};
    r_we = 1'b0; r_waddr = j_r[RaW-1:0]; r_wdata = {key_n_r, key_d_r};
    r_raddr = RaW'(j_r - PosW'(1));

    unique case (state_r)
      knnsc_pkg::S_IDLE: begin
        if (start) begin
          func_nxt = in_func; src_nxt = in_source_vertex; dst_nxt = in_target_vertex;
          dist_nxt = in_edge_distance; qv_nxt = in_query_vertex; qr_nxt = in_query_rank;
          stat_nxt = knnsc_pkg::ST_OK; nid_nxt = '0; ndist_nxt = '0; deg_nxt = '0;
          state_nxt = knnsc_pkg::S_EXEC;
        end
      end
      knnsc_pkg::S_EXEC: begin
        state_nxt = knnsc_pkg::S_DONE;
        case (func_r)
          knnsc_pkg::FUNC_LOAD: begin
            if ({1'b0, src_r} >= vc_r || {1'b0, dst_r} >= vc_r) begin
              stat_nxt = knnsc_pkg::ST_RANGE;
            end else if (src_r != dst_r) begin
              if (PosW'(loaded_r) >= cap) begin
                stat_nxt = knnsc_pkg::ST_FULL;
              end else begin
                l_we = 1'b1;
                loaded_nxt = loaded_r + LcntW'(1);
              end
            end
          end
          knnsc_pkg::FUNC_BUILD: begin
            o_we = 1'b1; o_waddr = '0; o_wdata = '0;
            v_nxt = '0; pos_nxt = '0;
            state_nxt = knnsc_pkg::S_VSTART;
          end
          knnsc_pkg::FUNC_QUERY: begin
            if (!built_r) begin
              stat_nxt = knnsc_pkg::ST_NOT_BUILT;
            end else if ({1'b0, qv_r} >= vc_r) begin
              stat_nxt = knnsc_pkg::ST_RANGE;
            end else begin
              state_nxt = knnsc_pkg::S_Q1;   // offsets[qv] read issued here
            end
          end
          default: ;
        endcase
      end
      knnsc_pkg::S_Q1: begin
        base_nxt = ord_r;
        o_raddr = {1'b0, qv_r} + VcntW'(1);
        state_nxt = knnsc_pkg::S_Q2;
      end
      knnsc_pkg::S_Q2: begin
        deg_nxt = deg_w[VidW-1:0];
        r_raddr = RaW'(base_r + PosW'(qr_r));
        if (PosW'(qr_r) >= deg_w) begin
          stat_nxt = knnsc_pkg::ST_RANK;
          state_nxt = knnsc_pkg::S_DONE;
        end else begin
          state_nxt = knnsc_pkg::S_Q3;
        end
      end
      knnsc_pkg::S_Q3: begin
        nid_nxt = rrd_r[RwW-1 -: VidW];
        ndist_nxt = rrd_r[DistW-1:0];
        state_nxt = knnsc_pkg::S_DONE;
      end
      // ---- build: gather best distance per neighbor of vertex v ----
      knnsc_pkg::S_VSTART: begin
        seen_nxt = '0;
        start_nxt = pos_r;
        e_nxt = '0;
        u_nxt = '0;
        state_nxt = (loaded_r == '0) ? knnsc_pkg::S_UCHK : knnsc_pkg::S_SRD;
      end
      knnsc_pkg::S_SRD: begin
        state_nxt = knnsc_pkg::S_SCHK;
      end
      knnsc_pkg::S_SCHK: begin
        if (ls == v_r[VidW-1:0] || lt == v_r[VidW-1:0]) begin
          key_n_nxt = nbr;          // best[nbr] read issued here
          key_d_nxt = ld;
          state_nxt = knnsc_pkg::S_SUPD;
        end else begin
          e_nxt = e_r + LcntW'(1);
          state_nxt = (e_r + LcntW'(1) == loaded_r) ? knnsc_pkg::S_UCHK
                                                    : knnsc_pkg::S_SRD;
        end
      end
      knnsc_pkg::S_SUPD: begin
        if (!seen_r[key_n_r] || key_d_r < brd_r) begin
          b_we = 1'b1;
          seen_nxt[key_n_r] = 1'b1;
        end
        e_nxt = e_r + LcntW'(1);
        state_nxt = (e_r + LcntW'(1) == loaded_r) ? knnsc_pkg::S_UCHK
                                                  : knnsc_pkg::S_SRD;
      end
      // ---- build: insertion sort of unique neighbors into the row ----
      knnsc_pkg::S_UCHK: begin
        b_raddr = u_r[VidW-1:0];
        if (u_r == vc_r) begin
          state_nxt = knnsc_pkg::S_VEND;
        end else if (seen_r[u_r[VidW-1:0]]) begin
          state_nxt = knnsc_pkg::S_UKEY;
        end else begin
          u_nxt = u_r + VcntW'(1);
        end
      end
      knnsc_pkg::S_UKEY: begin
        key_d_nxt = brd_r;
        key_n_nxt = u_r[VidW-1:0];
        j_nxt = pos_r;
        state_nxt = knnsc_pkg::S_SHRD;
      end
      knnsc_pkg::S_SHRD: begin
        if (j_r > start_r) begin
          state_nxt = knnsc_pkg::S_SHCMP;
        end else begin
          r_we = 1'b1;
          pos_nxt = pos_r + PosW'(1);
          u_nxt = u_r + VcntW'(1);
          state_nxt = knnsc_pkg::S_UCHK;
        end
      end
      knnsc_pkg::S_SHCMP: begin
        r_we = 1'b1;
        if (knnsc_pkg::key_after(rrd_r[DistW-1:0], rrd_r[RwW-1 -: VidW],
                                 key_d_r, key_n_r)) begin
          r_wdata = rrd_r;
          j_nxt = j_r - PosW'(1);
          state_nxt = knnsc_pkg::S_SHRD;
        end else begin
          pos_nxt = pos_r + PosW'(1);
          u_nxt = u_r + VcntW'(1);
          state_nxt = knnsc_pkg::S_UCHK;
        end
      end
      knnsc_pkg::S_VEND: begin
        o_we = 1'b1;
        v_nxt = v_inc;
        if (v_inc == vc_r) begin
          built_nxt = 1'b1;
          loaded_nxt = '0;
          total_nxt = pos_r;
          state_nxt = knnsc_pkg::S_DONE;
        end else begin
          state_nxt = knnsc_pkg::S_VSTART;
        end
      end
      knnsc_pkg::S_DONE: begin
        ov_nxt = 1'b1;
        os_nxt = stat_r; on_nxt = nid_r; od_nxt = ndist_r; odeg_nxt = deg_r;
        ot_nxt = built_r ? 14'(total_r) : 14'(loaded_r);
        state_nxt = knnsc_pkg::S_IDLE;
      end
      default: state_nxt = knnsc_pkg::S_IDLE;
    endcase

    // register writes: out-of-range values clamp, graph is dropped
    if (cfg_we && cfg_index == knnsc_pkg::REG_VERTEX_COUNT) begin
      if (cfg_wdata == '0) vc_nxt = VcntW'(1);
      else if (cfg_wdata > 9'(knnsc_pkg::MaxVertices))
        vc_nxt = VcntW'(knnsc_pkg::MaxVertices);
      else vc_nxt = cfg_wdata[VcntW-1:0];
      loaded_nxt = '0;
      built_nxt = 1'b0;
    end else if (cfg_we && cfg_index == knnsc_pkg::REG_NEIGHBORS) begin
      if (cfg_wdata[4:0] == '0) npr_nxt = NcntW'(1);
      else if (cfg_wdata[4:0] > 5'(knnsc_pkg::MaxNeighbors))
        npr_nxt = NcntW'(knnsc_pkg::MaxNeighbors);
      else npr_nxt = cfg_wdata[NcntW-1:0];
      loaded_nxt = '0;
      built_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= knnsc_pkg::S_IDLE;
      vc_r <= VcntW'(knnsc_pkg::MaxVertices);
      npr_r <= NcntW'(knnsc_pkg::MaxNeighbors);
      loaded_r <= '0;
      built_r <= 1'b0;
      total_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vc_r <= vc_nxt;
      npr_r <= npr_nxt;
      loaded_r <= loaded_nxt;
      built_r <= built_nxt;
      total_r <= total_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt; src_r <= src_nxt; dst_r <= dst_nxt; dist_r <= dist_nxt;
    qv_r <= qv_nxt; qr_r <= qr_nxt;
    v_r <= v_nxt; u_r <= u_nxt; e_r <= e_nxt; pos_r <= pos_nxt; start_r <= start_nxt;
    j_r <= j_nxt; base_r <= base_nxt; key_d_r <= key_d_nxt; key_n_r <= key_n_nxt;
    seen_r <= seen_nxt;
    stat_r <= stat_nxt; nid_r <= nid_nxt; deg_r <= deg_nxt; ndist_r <= ndist_nxt;
    os_r <= os_nxt; on_r <= on_nxt; od_r <= od_nxt; odeg_r <= odeg_nxt; ot_r <= ot_nxt;
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (l_we) lmem[loaded_r[LaW-1:0]] <= {src_r, dst_r, dist_r};
    lrd_r <= lmem[l_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) bmem[b_waddr] <= b_wdata;
    brd_r <= bmem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (o_we) omem[o_waddr] <= o_wdata;
    ord_r <= omem[o_raddr];
  end

  always_ff @(posedge clk) begin
    if (r_we) rmem[r_waddr] <= r_wdata;
    rrd_r <= rmem[r_raddr];
  end

  // checks
  a_strobe_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == knnsc_pkg::S_DONE))
    else $error("result strobe without completion");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not start");

  a_load_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    PosW'(loaded_r) <= cap)
    else $error("load store count beyond capacity");

  a_built_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(built_r) |-> $past(cfg_we))
    else $error("built graph dropped without register write");

endmodule

// ----- tb/sv/knn_graph_symmetric_csr_builder_core_test.sv -----
// ----------------------------------------------------------------------------
// knn_graph_symmetric_csr_builder_core_test: self-checking bench for the core
// Drives load, build, query and no-op requests plus register writes, predicts
// every result with a behavioral graph model and checks each strobed result.
// ----------------------------------------------------------------------------
module knn_graph_symmetric_csr_builder_core_test;

  localparam logic [1:0] FUNC_NOP = 2'd3;    // unused code, acts as a no-op
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [31:0] edist;
    logic [7:0]  qv;
    logic [7:0]  qr;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  nid;
    logic [31:0] ndist;
    logic [7:0]  deg;
    logic [13:0] total;
  } answer_t;

  // directed table row: a request or a register write, optionally with a
  // hand-typed answer
  typedef struct {
    bit          is_cfg;
    logic [1:0]  cfg_idx;
    logic [8:0]  cfg_val;
    request_t    req;
    bit          typed;
    answer_t     ans;
  } step_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [7:0]  in_source_vertex;
  logic [7:0]  in_target_vertex;
  logic [31:0] in_edge_distance;
  logic [7:0]  in_query_vertex;
  logic [7:0]  in_query_rank;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [7:0]  out_neighbor_id;
  logic [31:0] out_neighbor_distance;
  logic [7:0]  out_row_degree;
  logic [13:0] out_total_edges;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_wdata;

  knn_graph_symmetric_csr_builder_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_func              (in_func),
    .in_source_vertex     (in_source_vertex),
    .in_target_vertex     (in_target_vertex),
    .in_edge_distance     (in_edge_distance),
    .in_query_vertex      (in_query_vertex),
    .in_query_rank        (in_query_rank),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_neighbor_id      (out_neighbor_id),
    .out_neighbor_distance(out_neighbor_distance),
    .out_row_degree       (out_row_degree),
    .out_total_edges      (out_total_edges),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Graph model state: registers, load store, compressed rows
  // --------------------------------------------------------------------------
  int unsigned gm_vcount;
  int unsigned gm_nper;
  logic [7:0]  gm_ld_src  [knnsc_pkg::LoadDepth];
  logic [7:0]  gm_ld_dst  [knnsc_pkg::LoadDepth];
  logic [31:0] gm_ld_dist [knnsc_pkg::LoadDepth];
  int unsigned gm_ld_cnt;
  int unsigned gm_offs    [knnsc_pkg::MaxVertices+1];
  logic [7:0]  gm_row_nb  [knnsc_pkg::RowDepth];
  logic [31:0] gm_row_dist[knnsc_pkg::RowDepth];
  bit          gm_built;

  answer_t     pending_answers[$];
  int          mismatches;
  int          items_sent;
  int          builds_sent;
  int          queries_sent;
  int          cfg_writes;
  int          cycles;

  always #1 clk = ~clk;

  // register value: zero acts as one, above the maximum acts as the maximum
  function automatic int unsigned clamp_field(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void model_write_reg(logic [1:0] idx, logic [8:0] val);
    if (idx == knnsc_pkg::REG_VERTEX_COUNT) begin
      gm_vcount = clamp_field(32'(val), knnsc_pkg::MaxVertices);
    end else if (idx == knnsc_pkg::REG_NEIGHBORS) begin
      gm_nper = clamp_field(32'(val[4:0]), knnsc_pkg::MaxNeighbors);
    end else begin
      return;
    end
    gm_ld_cnt = 0;
    gm_built  = 0;
  endfunction

  // symmetric rows: every loaded edge both ways, min distance per neighbor,
  // each row sorted by (distance, neighbor id)
  function automatic void model_build_rows();
    bit          seen[knnsc_pkg::MaxVertices];
    logic [31:0] best[knnsc_pkg::MaxVertices];
    int unsigned pos;
    int unsigned row_base;
    int unsigned nb;
    int unsigned j;
    pos = 0;
    gm_offs[0] = 0;
    for (int unsigned v = 0; v < gm_vcount; v++) begin
      row_base = pos;
      foreach (seen[i]) seen[i] = 0;
      for (int unsigned e = 0; e < gm_ld_cnt; e++) begin
        if (gm_ld_src[e] == v) nb = 32'(gm_ld_dst[e]);
        else if (gm_ld_dst[e] == v) nb = 32'(gm_ld_src[e]);
        else continue;
        if (!seen[nb] || gm_ld_dist[e] < best[nb]) begin
          seen[nb] = 1;
          best[nb] = gm_ld_dist[e];
        end
      end
      for (int unsigned u = 0; u < gm_vcount; u++) begin
        if (!seen[u]) continue;
        j = pos;
        while (j > row_base && (gm_row_dist[j-1] > best[u] ||
               (gm_row_dist[j-1] == best[u] && gm_row_nb[j-1] > u))) begin
          gm_row_dist[j] = gm_row_dist[j-1];
          gm_row_nb[j]   = gm_row_nb[j-1];
          j--;
        end
        gm_row_dist[j] = best[u];
        gm_row_nb[j]   = 8'(u);
        pos++;
      end
      gm_offs[v+1] = pos;
    end
    gm_built  = 1;
    gm_ld_cnt = 0;
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t     a;
    int unsigned base;
    int unsigned deg;
    a = '{status: knnsc_pkg::ST_OK, nid: '0, ndist: '0, deg: '0, total: '0};
    case (r.func)
      knnsc_pkg::FUNC_LOAD: begin
        if (r.src >= gm_vcount || r.dst >= gm_vcount) begin
          a.status = knnsc_pkg::ST_RANGE;
        end else if (r.src != r.dst) begin
          if (gm_ld_cnt >= gm_vcount * gm_nper) begin
            a.status = knnsc_pkg::ST_FULL;
          end else begin
            gm_ld_src[gm_ld_cnt]  = r.src;
            gm_ld_dst[gm_ld_cnt]  = r.dst;
            gm_ld_dist[gm_ld_cnt] = r.edist;
            gm_ld_cnt++;
          end
        end
      end
      knnsc_pkg::FUNC_BUILD: model_build_rows();
      knnsc_pkg::FUNC_QUERY: begin
        if (!gm_built) begin
          a.status = knnsc_pkg::ST_NOT_BUILT;
        end else if (r.qv >= gm_vcount) begin
          a.status = knnsc_pkg::ST_RANGE;
        end else begin
          base  = gm_offs[r.qv];
          deg   = gm_offs[r.qv+1] - base;
          a.deg = deg[7:0];
          if (r.qr >= deg) begin
            a.status = knnsc_pkg::ST_RANK;
          end else begin
            a.nid   = gm_row_nb[base + r.qr];
            a.ndist = gm_row_dist[base + r.qr];
          end
        end
      end
      default: ;
    endcase
    a.total = gm_built ? 14'(gm_offs[gm_vcount]) : 14'(gm_ld_cnt);
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: one result per request, in order
  // --------------------------------------------------------------------------
  answer_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result, status %0d total %0d", out_status,
                   out_total_edges);
      end else begin
        want = pending_answers.pop_front();
        if (out_status !== want.status || out_neighbor_id !== want.nid ||
            out_neighbor_distance !== want.ndist || out_row_degree !== want.deg ||
            out_total_edges !== want.total) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: result mismatch exp st %0d id %0d dist %h deg %0d",
                      " tot %0d / got st %0d id %0d dist %h deg %0d tot %0d"},
                     want.status, want.nid, want.ndist, want.deg, want.total,
                     out_status, out_neighbor_id, out_neighbor_distance,
                     out_row_degree, out_total_edges);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver. start stays high between back-to-back requests; busy
  // rises the cycle after accept so a held start is never taken twice.
  // --------------------------------------------------------------------------
  task automatic send_request(request_t r, int idle_pct, bit typed, answer_t typed_ans);
    answer_t a;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start            <= 1'b1;
    in_func          <= r.func;
    in_source_vertex <= r.src;
    in_target_vertex <= r.dst;
    in_edge_distance <= r.edist;
    in_query_vertex  <= r.qv;
    in_query_rank    <= r.qr;
    do @(posedge clk); while (busy);
    a = predict_answer(r);
    pending_answers.push_back(typed ? typed_ans : a);
    items_sent++;
    if (r.func == knnsc_pkg::FUNC_BUILD) builds_sent++;
    if (r.func == knnsc_pkg::FUNC_QUERY) queries_sent++;
  endtask

  // register writes only once every request has drained
  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_write_reg(idx, val);
    cfg_writes++;
  endtask

  function automatic request_t mk_req(logic [1:0] f, logic [7:0] s, logic [7:0] d,
                                      logic [31:0] ed, logic [7:0] qv, logic [7:0] qr);
    request_t r;
    r = '{func: f, src: s, dst: d, edist: ed, qv: qv, qr: qr};
    return r;
  endfunction

  function automatic logic [31:0] rand_dist();
    // small values force ties and duplicate merges
    if ($urandom_range(2) == 0) return $urandom_range(3);
    return $urandom();
  endfunction

  function automatic logic [7:0] rand8();
    return 8'($urandom());
  endfunction

  // one random scenario: configure, load, build, query
  task automatic run_scenario(int idle_pct);
    answer_t     none;
    request_t    r;
    int unsigned pick;
    int unsigned nloads;
    int unsigned nq;
    int unsigned deg;
    none = '{status: '0, nid: '0, ndist: '0, deg: '0, total: '0};
    pick = $urandom_range(99);
    if (pick < 8)
      write_reg(knnsc_pkg::REG_VERTEX_COUNT, 9'($urandom_range(256, 511)));
    else if (pick < 14)
      write_reg(knnsc_pkg::REG_VERTEX_COUNT, 9'($urandom_range(1)));
    else if (pick < 60)
      write_reg(knnsc_pkg::REG_VERTEX_COUNT, 9'($urandom_range(2, 8)));
    else
      write_reg(knnsc_pkg::REG_VERTEX_COUNT, 9'($urandom_range(2, 40)));
    if ($urandom_range(1)) write_reg(knnsc_pkg::REG_NEIGHBORS, 9'($urandom_range(31)));

    if ($urandom_range(19) == 0)
      send_request(mk_req(knnsc_pkg::FUNC_QUERY, rand8(), rand8(), $urandom(), rand8(),
                          rand8()), idle_pct, 0, none);

    // big graphs build slowly: keep their edge count low
    if (gm_vcount > 64) nloads = $urandom_range(24);
    else nloads = $urandom_range(gm_vcount * gm_nper + 3 < 80 ?
                                 gm_vcount * gm_nper + 3 : 80);
    for (int i = 0; i < nloads; i++) begin
      if ($urandom_range(99) < 85)
        r = mk_req(knnsc_pkg::FUNC_LOAD, 8'($urandom_range(gm_vcount - 1)),
                   8'($urandom_range(gm_vcount - 1)), rand_dist(), rand8(), rand8());
      else if ($urandom_range(3) == 0)
        r = mk_req(FUNC_NOP, rand8(), rand8(), $urandom(), rand8(), rand8());
      else
        r = mk_req(knnsc_pkg::FUNC_LOAD, rand8(), rand8(), $urandom(), rand8(), rand8());
      send_request(r, idle_pct, 0, none);
    end

    send_request(mk_req(knnsc_pkg::FUNC_BUILD, rand8(), rand8(), $urandom(), rand8(),
                        rand8()), idle_pct, 0, none);

    nq = $urandom_range(5, 20);
    for (int i = 0; i < nq; i++) begin
      r = mk_req(knnsc_pkg::FUNC_QUERY, rand8(), rand8(), $urandom(),
                 8'($urandom_range(gm_vcount - 1)), 0);
      deg = gm_offs[r.qv + 1] - gm_offs[r.qv];
      r.qr = 8'($urandom_range(deg));
      if ($urandom_range(9) == 0) begin
        r.qv = rand8();
        r.qr = rand8();
      end
      send_request(r, idle_pct, 0, none);
      // an occasional late load: the built graph must stay queryable
      if ($urandom_range(9) == 0)
        send_request(mk_req(knnsc_pkg::FUNC_LOAD, 8'($urandom_range(gm_vcount - 1)),
                            8'($urandom_range(gm_vcount - 1)), rand_dist(), rand8(),
                            rand8()), idle_pct, 0, none);
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table, then random scenarios in three idle phases
  // --------------------------------------------------------------------------
  step_t script[$];

  function automatic void add_req(request_t r, bit typed, logic [2:0] st, logic [13:0] tot);
    step_t s;
    s.is_cfg  = 0;
    s.cfg_idx = '0;
    s.cfg_val = '0;
    s.req     = r;
    s.typed   = typed;
    s.ans     = '{status: st, nid: '0, ndist: '0, deg: '0, total: tot};
    script.push_back(s);
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [8:0] val);
    step_t s;
    s.is_cfg  = 1;
    s.cfg_idx = idx;
    s.cfg_val = val;
    s.req     = mk_req(FUNC_NOP, 0, 0, 0, 0, 0);
    s.typed   = 0;
    s.ans     = '{status: '0, nid: '0, ndist: '0, deg: '0, total: '0};
    script.push_back(s);
  endfunction

  initial begin
    clk = 0; rst_n = 0; start = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_func = '0; in_source_vertex = '0; in_target_vertex = '0;
    in_edge_distance = '0; in_query_vertex = '0; in_query_rank = '0;
    mismatches = 0; items_sent = 0; builds_sent = 0; queries_sent = 0;
    cfg_writes = 0; cycles = 0;
    gm_vcount = knnsc_pkg::MaxVertices; gm_nper = knnsc_pkg::MaxNeighbors;
    gm_ld_cnt = 0; gm_built = 0;
    foreach (gm_offs[i]) gm_offs[i] = 0;

    // after reset: nothing built, defaults 256 x 16
    add_req(mk_req(knnsc_pkg::FUNC_QUERY, 0, 0, 0, 0, 0), 1, knnsc_pkg::ST_NOT_BUILT, 0);
    add_req(mk_req(FUNC_NOP, 8'hff, 8'hff, 32'hffffffff, 8'hff, 8'hff), 1,
            knnsc_pkg::ST_OK, 0);
    add_req(mk_req(knnsc_pkg::FUNC_LOAD, 0, 255, 32'hffffffff, 0, 0), 1, knnsc_pkg::ST_OK, 1);
    add_req(mk_req(knnsc_pkg::FUNC_LOAD, 5, 5, 32'h1, 0, 0), 1,
            knnsc_pkg::ST_OK, 1);                                     // self-loop skipped
    add_req(mk_req(knnsc_pkg::FUNC_LOAD, 255, 0, 32'h0, 0, 0), 1,
            knnsc_pkg::ST_OK, 2);                                     // reverse duplicate
    add_req(mk_req(knnsc_pkg::FUNC_LOAD, 0, 255, 32'h7, 0, 0), 1, knnsc_pkg::ST_OK, 3);
    add_req(mk_req(knnsc_pkg::FUNC_LOAD, 1, 0, 32'h0, 0, 0), 1,
            knnsc_pkg::ST_OK, 4);                                     // distance tie
    add_req(mk_req(knnsc_pkg::FUNC_BUILD, 0, 0, 0, 0, 0), 0, knnsc_pkg::ST_OK, 0);
    add_req(mk_req(knnsc_pkg::FUNC_QUERY, 0, 0, 0, 0, 0), 0, knnsc_pkg::ST_OK, 0);
    add_req(mk_req(knnsc_pkg::FUNC_QUERY, 0, 0, 0, 0, 1), 0, knnsc_pkg::ST_OK, 0);
    add_req(mk_req(knnsc_pkg::FUNC_QUERY, 0, 0, 0, 0, 2), 0,
            knnsc_pkg::ST_OK, 0);                                     // rank past degree
    add_req(mk_req(knnsc_pkg::FUNC_QUERY, 0, 0, 0, 255, 0), 0, knnsc_pkg::ST_OK, 0);
    add_req(mk_req(knnsc_pkg::FUNC_QUERY, 0, 0, 0, 200, 255), 0,
            knnsc_pkg::ST_OK, 0);                                     // empty row
    add_req(mk_req(knnsc_pkg::FUNC_LOAD, 3, 4, 1, 0, 0), 0,
            knnsc_pkg::ST_OK, 0);                                     // load after build
    add_req(mk_req(knnsc_pkg::FUNC_QUERY, 0, 0, 0, 1, 0), 0, knnsc_pkg::ST_OK, 0);
    // vertex count zero acts as one
    add_cfg(knnsc_pkg::REG_VERTEX_COUNT, 0);
    add_req(mk_req(knnsc_pkg::FUNC_LOAD, 0, 1, 5, 0, 0), 1, knnsc_pkg::ST_RANGE, 0);
    add_req(mk_req(knnsc_pkg::FUNC_QUERY, 0, 0, 0, 0, 0), 1, knnsc_pkg::ST_NOT_BUILT, 0);
    add_req(mk_req(knnsc_pkg::FUNC_BUILD, 0, 0, 0, 0, 0), 0,
            knnsc_pkg::ST_OK, 0);                                     // empty graph
    add_req(mk_req(knnsc_pkg::FUNC_QUERY, 0, 0, 0, 0, 0), 0, knnsc_pkg::ST_OK, 0);
    add_req(mk_req(knnsc_pkg::FUNC_QUERY, 0, 0, 0, 1, 0), 0,
            knnsc_pkg::ST_OK, 0);                                     // vertex out of range
    // capacity of two edges: third load overflows
    add_cfg(knnsc_pkg::REG_VERTEX_COUNT, 2);
    add_cfg(knnsc_pkg::REG_NEIGHBORS, 0);
    add_req(mk_req(knnsc_pkg::FUNC_LOAD, 0, 1, 5, 0, 0), 1, knnsc_pkg::ST_OK, 1);
    add_req(mk_req(knnsc_pkg::FUNC_LOAD, 1, 0, 3, 0, 0), 1, knnsc_pkg::ST_OK, 2);
    add_req(mk_req(knnsc_pkg::FUNC_LOAD, 1, 0, 9, 0, 0), 1, knnsc_pkg::ST_FULL, 2);
    add_cfg(knnsc_pkg::REG_NEIGHBORS, 31);                            // clamps to max
    add_cfg(knnsc_pkg::REG_VERTEX_COUNT, 511);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) write_reg(script[i].cfg_idx, script[i].cfg_val);
      else send_request(script[i].req, 15, script[i].typed, script[i].ans);
    end

    // sender idles 15%, then 87%, then never
    while (items_sent < 470) run_scenario(15);
    while (items_sent < 920) run_scenario(87);
    while (items_sent < 1370) run_scenario(0);

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d requests (%0d builds, %0d queries) and %0d register writes",
             items_sent, builds_sent, queries_sent, cfg_writes);
    $display("over %0d cycles with %0d mismatches", cycles, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- knn_graph_symmetric_csr_builder_core.f -----
rtl/knnsc_pkg.sv
rtl/knn_graph_symmetric_csr_builder_core.sv
tb/sv/knn_graph_symmetric_csr_builder_core_test.sv
